### src/min_plus_shortcut_query_defines.svh
// Assertion macros shared by the min-plus shortcut query RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef MIN_PLUS_SHORTCUT_QUERY_DEFINES_SVH
`define MIN_PLUS_SHORTCUT_QUERY_DEFINES_SVH

// same-cycle implication
`define MSPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mspq_pkg.sv
// Shared types and constants for the min-plus shortcut query block.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps
package mspq_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_DIST_BITS    = 16;

  // fixed beat field widths
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int DIST_W = 16;
  localparam int SIZE_W = 5;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [0:0] REG_SIZE_IN_USE = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_en;     // store the incoming element
    logic start;     // latch query indexes, preset minimum to infinity
    logic issue;     // read row and column element at k
    logic load_out;  // move the minimum into the result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new beat this cycle
  } dp_sts_t;

endpackage

### src/mspq_if.sv
// Valid/ready channel interfaces for query requests and results.
// Depends on mspq_pkg for the field widths.
`timescale 1ns / 1ps
interface mspq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [mspq_pkg::ROW_W-1:0] row;
  logic [mspq_pkg::COL_W-1:0] col;
  logic [mspq_pkg::DIST_W-1:0] dist_req;

  modport source (output valid, req_type, row, col, dist_req, input ready);
  modport sink   (input valid, req_type, row, col, dist_req, output ready);
endinterface

interface mspq_out_if;
  logic                        valid;
  logic                        ready;
  logic [mspq_pkg::ROW_W-1:0]  res_row;
  logic [mspq_pkg::COL_W-1:0]  res_col;
  logic [mspq_pkg::DIST_W-1:0] shortest;

  modport source (output valid, res_row, res_col, shortest, input ready);
  modport sink   (input valid, res_row, res_col, shortest, output ready);
endinterface

### src/min_plus_shortcut_query.sv
// Top level of the min-plus shortcut query block.
// Depends on mspq_pkg, mspq_if, mspq_ctrl and mspq_datapath.
`timescale 1ns / 1ps
// Holds a MAX_VERTICES x MAX_VERTICES distance matrix (all-ones = infinity)
// and answers queries min over k < n of d[row][k] + d[k][col], saturating.
// A write beat with in-range indexes is stored as it is accepted. A query
// beat holds the block through ST_SCAN, which reads for each k < n (n =
// size_in_use clamped to MAX_VERTICES; the matrix memory has two read ports,
// so one row element and one column element are read per cycle), ST_DRAIN,
// which folds the last read, and ST_DONE, which loads the result register.
// Out-of-range indexes or size zero skip to ST_DONE and answer infinity. A
// query whose result register is still held by an untaken beat waits in
// ST_DONE. New beats are accepted while a finished result waits to be taken.
// The matrix has no reset; read entries must have been written first.
// size_in_use sits at APB address 0 and resets to 16.
module min_plus_shortcut_query #(
  parameter int MAX_VERTICES = mspq_pkg::DEF_MAX_VERTICES,
  parameter int DIST_BITS    = mspq_pkg::DEF_DIST_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mspq_in_if.sink                         in_ch,
  mspq_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mspq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mspq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mspq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  mspq_pkg::dp_cmd_t                 cmd;
  mspq_pkg::dp_sts_t                 sts;
  logic [$clog2(MAX_VERTICES)-1:0]   k_idx;

  mspq_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_row      (in_ch.row),
    .in_col      (in_ch.col),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cmd         (cmd),
    .k_idx       (k_idx),
    .sts         (sts)
  );

  mspq_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .DIST_BITS    (DIST_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .k_idx     (k_idx),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_dist   (in_ch.dist_req),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res_row   (out_ch.res_row),
    .res_col   (out_ch.res_col),
    .shortest  (out_ch.shortest)
  );

endmodule

### src/mspq_datapath.sv
// Datapath: distance matrix memory with two read ports, saturating add,
// running minimum and the result register. Depends on mspq_pkg.
`timescale 1ns / 1ps
module mspq_datapath #(
  parameter int MAX_VERTICES = mspq_pkg::DEF_MAX_VERTICES,
  parameter int DIST_BITS    = mspq_pkg::DEF_DIST_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mspq_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]   k_idx,
  input  logic [mspq_pkg::ROW_W-1:0]        in_row,
  input  logic [mspq_pkg::COL_W-1:0]        in_col,
  input  logic [mspq_pkg::DIST_W-1:0]       in_dist,
  output mspq_pkg::dp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mspq_pkg::ROW_W-1:0]        res_row,
  output logic [mspq_pkg::COL_W-1:0]        res_col,
  output logic [mspq_pkg::DIST_W-1:0]       shortest
);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int DEPTH = 1 << (2 * IDX_W);
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  logic [DIST_BITS-1:0] mem [DEPTH];

  logic [IDX_W-1:0]           q_row_r;
  logic [IDX_W-1:0]           q_col_r;
  logic [mspq_pkg::ROW_W-1:0] q_row_tag_r;
  logic [mspq_pkg::COL_W-1:0] q_col_tag_r;
  logic [DIST_BITS-1:0]       rd_a_r;
  logic [DIST_BITS-1:0]       rd_b_r;
  logic                       fold_r;
  logic [DIST_BITS-1:0]       best_r;
  logic [DIST_BITS-1:0]       best_nxt;
  logic                       out_valid_r;
  logic [mspq_pkg::ROW_W-1:0] res_row_r;
  logic [mspq_pkg::COL_W-1:0] res_col_r;
  logic [mspq_pkg::DIST_W-1:0] shortest_r;

  logic [DIST_BITS:0]   raw_sum;
  logic [DIST_BITS-1:0] sat_sum;

  // matrix store, row-major {row, col}
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[{IDX_W'(in_row), IDX_W'(in_col)}] <= DIST_BITS'(in_dist);
    end
    rd_a_r <= mem[{q_row_r, k_idx}];
    rd_b_r <= mem[{k_idx, q_col_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_row_r     <= IDX_W'(in_row);
      q_col_r     <= IDX_W'(in_col);
      q_row_tag_r <= in_row;
      q_col_tag_r <= in_col;
    end
  end

  always_comb begin
    raw_sum = {1'b0, rd_a_r} + {1'b0, rd_b_r};
    if ((rd_a_r == DIST_INF) || (rd_b_r == DIST_INF) || (raw_sum >= {1'b0, DIST_INF})) begin
      sat_sum = DIST_INF;
    end else begin
      sat_sum = raw_sum[DIST_BITS-1:0];
    end
    if (cmd.start) begin
      best_nxt = DIST_INF;
    end else if (fold_r && (sat_sum < best_r)) begin
      best_nxt = sat_sum;
    end else begin
      best_nxt = best_r;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fold_r <= cmd.issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_row_r  <= q_row_tag_r;
      res_col_r  <= q_col_tag_r;
      shortest_r <= mspq_pkg::DIST_W'(best_r);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign res_row      = res_row_r;
  assign res_col      = res_col_r;
  assign shortest     = shortest_r;

`include "min_plus_shortcut_query_defines.svh"

  // the last read must be folded before the minimum is handed out
  `MSPQ_ASSERT_IMP(a_load_after_fold, cmd.load_out, !fold_r, "result loaded before last fold")
  `MSPQ_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid_r, "loaded beat not marked valid")
  `MSPQ_ASSERT_IMP(a_hold_stalled_beat, out_valid_r && !out_ready, !cmd.load_out,
                   "waiting result beat overwritten")

endmodule

### src/mspq_ctrl.sv
// Controller: state machine sequencing writes and query scans, plus the
// APB size register. Depends on mspq_pkg and the assertion macro header.
`timescale 1ns / 1ps
module mspq_ctrl #(
  parameter int MAX_VERTICES = mspq_pkg::DEF_MAX_VERTICES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [mspq_pkg::ROW_W-1:0]          in_row,
  input  logic [mspq_pkg::COL_W-1:0]          in_col,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mspq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mspq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mspq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mspq_pkg::dp_cmd_t                   cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]     k_idx,
  input  mspq_pkg::dp_sts_t                   sts
);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  mspq_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [mspq_pkg::SIZE_W-1:0] size_r;
  logic [CNT_W-1:0] n_eff;
  logic             idx_ok;
  logic             fire;
  logic             reg_sel;

  // APB register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[mspq_pkg::APB_ADDR_W-1:2] == mspq_pkg::REG_SIZE_IN_USE);
  assign prdata  = reg_sel ? mspq_pkg::APB_DATA_W'(size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= mspq_pkg::SIZE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      size_r <= pwdata[mspq_pkg::SIZE_W-1:0];
    end
  end

  // sizes above the matrix side clamp to it
  assign n_eff  = (int'(size_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(size_r);
  assign idx_ok = (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);
  assign fire   = in_valid && in_ready;
  assign k_idx  = k_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspq_pkg::ST_IDLE;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mspq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (fire) begin
          if (in_req_type == mspq_pkg::REQ_WRITE) begin
            cmd.wr_en = idx_ok;
          end else begin
            cmd.start = 1'b1;
            k_nxt     = '0;
            n_nxt     = n_eff;
            // empty range or bad index: answer is infinity, no scan
            if (idx_ok && (n_eff != '0)) begin
              state_nxt = mspq_pkg::ST_SCAN;
            end else begin
              state_nxt = mspq_pkg::ST_DONE;
            end
          end
        end
      end
      mspq_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + CNT_W'(1);
        if (k_nxt == n_r) begin
          state_nxt = mspq_pkg::ST_DRAIN;
        end
      end
      mspq_pkg::ST_DRAIN: begin
        state_nxt = mspq_pkg::ST_DONE;
      end
      mspq_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = mspq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mspq_pkg::ST_IDLE;
      end
    endcase
  end

`include "min_plus_shortcut_query_defines.svh"

  `MSPQ_ASSERT_IMP(a_k_in_range, state_r == mspq_pkg::ST_SCAN, k_r < n_r, "scan index past size")
  `MSPQ_ASSERT_IMP(a_drain_after_scan, state_r == mspq_pkg::ST_DRAIN,
                   $past(state_r) == mspq_pkg::ST_SCAN, "drain not preceded by scan")
  `MSPQ_ASSERT_NXT(a_load_to_idle, cmd.load_out, state_r == mspq_pkg::ST_IDLE,
                   "controller not idle after result load")

endmodule
